/* hdl/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the antialiased line rasterizer
// Command and pixel structs, line classes, register indexes.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int ERR_BITS     = 16;
    localparam int SCREEN_BITS  = 15;
    localparam int COV_BITS     = 8;
    localparam int CFG_IDX_BITS = 1;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR     = $clog2(FIFO_DEPTH);
    localparam int DIV_CNT_BITS = $clog2(ERR_BITS);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_COLS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_ROWS = 1'b1;

    localparam logic [COV_BITS-1:0] COV_FULL = 8'd255;

    typedef enum logic [2:0] {
        KIND_H    = 3'd0,
        KIND_V    = 3'd1,
        KIND_D    = 3'd2,
        KIND_YMAJ = 3'd3,
        KIND_XMAJ = 3'd4
    } line_kind_t;

    typedef struct packed {
        logic                          command;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic                          with_endpoint;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pixel_x;
        logic signed [COORD_WIDTH-1:0] pixel_y;
        logic [COV_BITS-1:0]           coverage;
        logic                          visible;
        logic                          last;
        logic                          line_done;
    } out_item_t;

    // Classified command passed from the front to the back.
    typedef struct packed {
        logic                          op;
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] ex;
        logic signed [COORD_WIDTH-1:0] ey;
        logic                          left;
        line_kind_t                    kind;
        logic [COORD_WIDTH-1:0]        steps;
        logic [ERR_BITS-1:0]           incr;
        logic                          endpoint;
    } alr_cmd_t;

endpackage

/* hdl/alr_div.sv */
// ----------------------------------------------------------------------------
// alr_div: iterative fraction divider
// Computes (num << ERR_BITS) / den for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alr_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [alr_pkg::COORD_WIDTH-1:0]   num,
    input  logic [alr_pkg::COORD_WIDTH-1:0]   den,
    output logic                              done,
    output logic [alr_pkg::ERR_BITS-1:0]      quot
);
    import alr_pkg::*;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t                 state_reg;
    logic [COORD_WIDTH-1:0]     rem_reg;
    logic [COORD_WIDTH-1:0]     den_reg;
    logic [ERR_BITS-1:0]        quot_reg;
    logic [DIV_CNT_BITS-1:0]    cnt_reg;
    logic                       done_reg;

    logic [COORD_WIDTH:0]       rem_shift;
    logic                       fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            quot_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= num;
                        den_reg   <= den;
                        cnt_reg   <= DIV_CNT_BITS'(ERR_BITS - 1);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    // remainder stays below den, so the difference fits
                    rem_reg  <= fits ? COORD_WIDTH'(rem_shift - {1'b0, den_reg})
                                     : rem_shift[COORD_WIDTH-1:0];
                    quot_reg <= {quot_reg[ERR_BITS-2:0], fits};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hdl/alr_front.sv */
// ----------------------------------------------------------------------------
// alr_front: command intake and line setup
// Orders endpoints, measures the deltas, classifies the line and computes
// the error increment, then queues the classified command.
// ----------------------------------------------------------------------------
module alr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  alr_pkg::in_item_t    in_item,
    output logic                 push,
    output alr_pkg::alr_cmd_t    cmd,
    input  logic                 fifo_full
);
    import alr_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ORDER,
        F_DIFF,
        F_ABS,
        F_CLASS,
        F_DIV,
        F_PUSH
    } front_state_t;

    front_state_t                  state_reg;
    in_item_t                      item_reg;
    logic signed [COORD_WIDTH-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [COORD_WIDTH:0]   dx_reg, dy_reg;
    logic [COORD_WIDTH-1:0]        adx_reg;
    logic                          left_reg;
    line_kind_t                    kind_reg;
    logic [COORD_WIDTH-1:0]        steps_reg;
    logic [ERR_BITS-1:0]           incr_reg;
    logic                          ep_reg;

    logic [COORD_WIDTH-1:0]        dyu;
    logic [COORD_WIDTH-1:0]        major;
    logic [COORD_WIDTH-1:0]        minor;
    logic                          div_start;
    logic                          div_done;
    logic [ERR_BITS-1:0]           div_quot;

    assign dyu       = dy_reg[COORD_WIDTH-1:0];
    assign major     = (dyu > adx_reg) ? dyu : adx_reg;
    assign minor     = (dyu > adx_reg) ? adx_reg : dyu;
    assign div_start = (state_reg == F_CLASS) && (dyu != '0) && (adx_reg != '0)
                       && (adx_reg != dyu);

    alr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (minor),
        .den   (major),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            item_reg  <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            ex_reg    <= '0;
            ey_reg    <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            adx_reg   <= '0;
            left_reg  <= 1'b0;
            kind_reg  <= KIND_H;
            steps_reg <= '0;
            incr_reg  <= '0;
            ep_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_item;
                        state_reg <= (in_item.command == CMD_START) ? F_ORDER : F_PUSH;
                    end
                end
                F_ORDER:
                begin
                    // y must rise along the line
                    if (item_reg.start_y > item_reg.end_y)
                    begin
                        sx_reg <= item_reg.end_x;
                        sy_reg <= item_reg.end_y;
                        ex_reg <= item_reg.start_x;
                        ey_reg <= item_reg.start_y;
                    end
                    else
                    begin
                        sx_reg <= item_reg.start_x;
                        sy_reg <= item_reg.start_y;
                        ex_reg <= item_reg.end_x;
                        ey_reg <= item_reg.end_y;
                    end
                    state_reg <= F_DIFF;
                end
                F_DIFF:
                begin
                    dx_reg    <= {ex_reg[COORD_WIDTH-1], ex_reg}
                                 - {sx_reg[COORD_WIDTH-1], sx_reg};
                    dy_reg    <= {ey_reg[COORD_WIDTH-1], ey_reg}
                                 - {sy_reg[COORD_WIDTH-1], sy_reg};
                    state_reg <= F_ABS;
                end
                F_ABS:
                begin
                    left_reg  <= dx_reg[COORD_WIDTH];
                    adx_reg   <= dx_reg[COORD_WIDTH] ? COORD_WIDTH'(-dx_reg)
                                                     : dx_reg[COORD_WIDTH-1:0];
                    state_reg <= F_CLASS;
                end
                F_CLASS:
                begin
                    incr_reg <= '0;
                    ep_reg   <= 1'b0;
                    priority if (dyu == '0)
                    begin
                        kind_reg  <= KIND_H;
                        steps_reg <= adx_reg;
                        state_reg <= F_PUSH;
                    end
                    else if (adx_reg == '0)
                    begin
                        kind_reg  <= KIND_V;
                        steps_reg <= dyu;
                        state_reg <= F_PUSH;
                    end
                    else if (adx_reg == dyu)
                    begin
                        kind_reg  <= KIND_D;
                        steps_reg <= dyu;
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        kind_reg  <= (dyu > adx_reg) ? KIND_YMAJ : KIND_XMAJ;
                        steps_reg <= major - 1'b1;
                        ep_reg    <= item_reg.with_endpoint;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    if (div_done)
                    begin
                        incr_reg  <= div_quot;
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!fifo_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != F_IDLE);
    assign push     = (state_reg == F_PUSH) && !fifo_full;

    always_comb
    begin
        cmd          = '0;
        cmd.op       = item_reg.command;
        cmd.sx       = sx_reg;
        cmd.sy       = sy_reg;
        cmd.ex       = ex_reg;
        cmd.ey       = ey_reg;
        cmd.left     = left_reg;
        cmd.kind     = kind_reg;
        cmd.steps    = steps_reg;
        cmd.incr     = incr_reg;
        cmd.endpoint = ep_reg;
    end

endmodule

/* hdl/alr_fifo.sv */
// ----------------------------------------------------------------------------
// alr_fifo: command queue between setup and stepping
// Small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module alr_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  alr_pkg::alr_cmd_t    push_cmd,
    output logic                 full,
    input  logic                 pop,
    output alr_pkg::alr_cmd_t    pop_cmd,
    output logic                 empty
);
    import alr_pkg::*;

    alr_cmd_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR-1:0]       wr_ptr_reg;
    logic [FIFO_PTR-1:0]       rd_ptr_reg;
    logic [FIFO_PTR:0]         count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign pop_cmd = mem[rd_ptr_reg];
    assign full    = (count_reg == (FIFO_PTR+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);

endmodule

/* hdl/alr_back.sv */
// ----------------------------------------------------------------------------
// alr_back: line stepper and pixel output
// Holds the line state, walks the line one command at a time and drives the
// registered pixel output with a visibility flag against the screen size.
// ----------------------------------------------------------------------------
module alr_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  alr_pkg::alr_cmd_t                  cmd,
    input  logic                               cmd_empty,
    output logic                               cmd_pop,
    input  logic [alr_pkg::SCREEN_BITS-1:0]    view_cols,
    input  logic [alr_pkg::SCREEN_BITS-1:0]    view_rows,
    output logic                               out_valid,
    input  logic                               out_stall,
    output alr_pkg::out_item_t                 out_item
);
    import alr_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PAIR,
        B_END
    } back_state_t;

    back_state_t                   state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] cx_reg, cx_next;
    logic signed [COORD_WIDTH-1:0] cy_reg, cy_next;
    logic signed [COORD_WIDTH-1:0] tx_reg, tx_next;
    logic signed [COORD_WIDTH-1:0] ty_reg, ty_next;
    logic                          left_reg, left_next;
    line_kind_t                    kind_reg, kind_next;
    logic [COORD_WIDTH-1:0]        steps_reg, steps_next;
    logic [ERR_BITS-1:0]           acc_reg, acc_next;
    logic [ERR_BITS-1:0]           incr_reg, incr_next;
    logic                          ep_reg, ep_next;
    logic                          active_reg, active_next;
    logic [COV_BITS-1:0]           w_reg, w_next;
    logic                          fin_reg, fin_next;
    logic                          out_valid_reg;
    out_item_t                     out_item_reg;

    logic                          slot_free;
    logic                          load;
    logic signed [COORD_WIDTH:0]   pix_x, pix_y;
    logic [COV_BITS-1:0]           pix_cov;
    logic                          pix_last, pix_done;
    logic                          pix_vis;

    logic signed [COORD_WIDTH-1:0] x_step;
    logic signed [COORD_WIDTH-1:0] y_step;
    logic [ERR_BITS-1:0]           acc_sum;
    logic                          wrap;
    logic [COORD_WIDTH-1:0]        steps_dec;
    logic                          ep_hit;

    assign slot_free = !out_valid_reg || !out_stall;
    assign x_step    = cx_reg + (left_reg ? -COORD_WIDTH'(1) : COORD_WIDTH'(1));
    assign y_step    = cy_reg + COORD_WIDTH'(1);
    assign acc_sum   = acc_reg + incr_reg;
    assign wrap      = (acc_sum <= acc_reg);   // carry out moves the minor axis
    assign steps_dec = steps_reg - 1'b1;
    assign ep_hit    = fin_reg && ep_reg;

    always_comb
    begin
        state_next  = state_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        left_next   = left_reg;
        kind_next   = kind_reg;
        steps_next  = steps_reg;
        acc_next    = acc_reg;
        incr_next   = incr_reg;
        ep_next     = ep_reg;
        active_next = active_reg;
        w_next      = w_reg;
        fin_next    = fin_reg;
        cmd_pop     = 1'b0;
        load        = 1'b0;
        pix_x       = '0;
        pix_y       = '0;
        pix_cov     = COV_FULL;
        pix_last    = 1'b1;
        pix_done    = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty && slot_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == CMD_START)
                    begin
                        cx_next     = cmd.sx;
                        cy_next     = cmd.sy;
                        tx_next     = cmd.ex;
                        ty_next     = cmd.ey;
                        left_next   = cmd.left;
                        kind_next   = cmd.kind;
                        steps_next  = cmd.steps;
                        acc_next    = '0;
                        incr_next   = cmd.incr;
                        ep_next     = cmd.endpoint;
                        active_next = (cmd.steps != '0);
                        load        = 1'b1;
                        pix_x       = {cmd.sx[COORD_WIDTH-1], cmd.sx};
                        pix_y       = {cmd.sy[COORD_WIDTH-1], cmd.sy};
                        pix_done    = (cmd.steps == '0);
                    end
                    else if (active_reg)
                    begin
                        steps_next = steps_dec;
                        unique case (kind_reg)
                            KIND_H, KIND_V, KIND_D:
                            begin
                                if (kind_reg != KIND_V)
                                begin
                                    cx_next = x_step;
                                end
                                if (kind_reg != KIND_H)
                                begin
                                    cy_next = y_step;
                                end
                                active_next = (steps_dec != '0);
                                load        = 1'b1;
                                pix_done    = (steps_dec == '0);
                            end
                            KIND_YMAJ, KIND_XMAJ:
                            begin
                                if (kind_reg == KIND_YMAJ)
                                begin
                                    cy_next = y_step;
                                    if (wrap)
                                    begin
                                        cx_next = x_step;
                                    end
                                end
                                else
                                begin
                                    cx_next = x_step;
                                    if (wrap)
                                    begin
                                        cy_next = y_step;
                                    end
                                end
                                acc_next   = acc_sum;
                                w_next     = acc_sum[ERR_BITS-1 -: COV_BITS];
                                fin_next   = (steps_dec == '0);
                                state_next = B_PAIR;
                                load       = 1'b1;
                                pix_cov    = COV_FULL - acc_sum[ERR_BITS-1 -: COV_BITS];
                                pix_last   = 1'b0;
                            end
                            default:
                            begin
                                active_next = 1'b0;
                            end
                        endcase
                        pix_x = {cx_next[COORD_WIDTH-1], cx_next};
                        pix_y = {cy_next[COORD_WIDTH-1], cy_next};
                    end
                end
            end
            B_PAIR:
            begin
                if (slot_free)
                begin
                    // neighbor may step one past the coordinate range
                    if (kind_reg == KIND_YMAJ)
                    begin
                        pix_x = {cx_reg[COORD_WIDTH-1], cx_reg}
                              + (left_reg ? -(COORD_WIDTH+1)'(1) : (COORD_WIDTH+1)'(1));
                        pix_y = {cy_reg[COORD_WIDTH-1], cy_reg};
                    end
                    else
                    begin
                        pix_x = {cx_reg[COORD_WIDTH-1], cx_reg};
                        pix_y = {cy_reg[COORD_WIDTH-1], cy_reg} + (COORD_WIDTH+1)'(1);
                    end
                    load     = 1'b1;
                    pix_cov  = w_reg;
                    pix_last = !ep_hit;
                    pix_done = fin_reg && !ep_hit;
                    if (fin_reg)
                    begin
                        active_next = 1'b0;
                    end
                    state_next = ep_hit ? B_END : B_IDLE;
                end
            end
            B_END:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    pix_x      = {tx_reg[COORD_WIDTH-1], tx_reg};
                    pix_y      = {ty_reg[COORD_WIDTH-1], ty_reg};
                    pix_done   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign pix_vis = !pix_x[COORD_WIDTH] && !pix_y[COORD_WIDTH]
                     && (pix_x[COORD_WIDTH-1:0] < COORD_WIDTH'(view_cols))
                     && (pix_y[COORD_WIDTH-1:0] < COORD_WIDTH'(view_rows));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cx_reg        <= '0;
            cy_reg        <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            left_reg      <= 1'b0;
            kind_reg      <= KIND_H;
            steps_reg     <= '0;
            acc_reg       <= '0;
            incr_reg      <= '0;
            ep_reg        <= 1'b0;
            active_reg    <= 1'b0;
            w_reg         <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            left_reg   <= left_next;
            kind_reg   <= kind_next;
            steps_reg  <= steps_next;
            acc_reg    <= acc_next;
            incr_reg   <= incr_next;
            ep_reg     <= ep_next;
            active_reg <= active_next;
            w_reg      <= w_next;
            fin_reg    <= fin_next;
            if (load)
            begin
                out_valid_reg          <= 1'b1;
                out_item_reg.pixel_x   <= pix_x[COORD_WIDTH-1:0];
                out_item_reg.pixel_y   <= pix_y[COORD_WIDTH-1:0];
                out_item_reg.coverage  <= pix_cov;
                out_item_reg.visible   <= pix_vis;
                out_item_reg.last      <= pix_last;
                out_item_reg.line_done <= pix_done;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* hdl/antialiased_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: error-accumulator antialiased line rasterizer
// Setup front end, command queue and stepping back end with visibility flags.
// ----------------------------------------------------------------------------
// A start command holds the setup front end through its order, difference,
// absolute-value, classify and push states; a general line also waits in the
// divide state for the one-bit-per-cycle divider that forms the error
// increment (16 quotient bits). A step command goes from idle straight to
// the push state, and no new command is taken until the last is pushed. The
// back end pops one queued command per free output slot and, while the output
// is not stalled, sends one pixel per cycle: one for axis and diagonal steps,
// two or three for general steps. A 2-entry queue between the two halves
// lets setup of the next command overlap pixel output of the current one.
// Screen size registers may be written only while no transfer is in flight.
module antialiased_line_rasterizer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [alr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [alr_pkg::SCREEN_BITS-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  alr_pkg::in_item_t                    in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output alr_pkg::out_item_t                   out_item
);
    import alr_pkg::*;

    logic [SCREEN_BITS-1:0] width_reg;
    logic [SCREEN_BITS-1:0] height_reg;

    logic                   push;
    alr_cmd_t               push_cmd;
    logic                   fifo_full;
    logic                   pop;
    alr_cmd_t               pop_cmd;
    logic                   fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_BITS'(640);
            height_reg <= SCREEN_BITS'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIEW_COLS: width_reg  <= cfg_data;
                REG_VIEW_ROWS: height_reg <= cfg_data;
                default:       width_reg  <= width_reg;
            endcase
        end
    end

    alr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .push      (push),
        .cmd       (push_cmd),
        .fifo_full (fifo_full)
    );

    alr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    alr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_empty (fifo_empty),
        .cmd_pop   (pop),
        .view_cols (width_reg),
        .view_rows (height_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the antialiased line rasterizer
// A scoreboard class predicts every pixel of each accepted command and checks
// the pixel stream in order, field by field. Directed lines come first, then
// random lines under several screen sizes, with random idling on both sides
// and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

    import alr_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 100;
    localparam int STUCK_LIMIT   = 4000;

    class pixel_scoreboard;
        out_item_t           pixel_queue[$];
        int                  errors;
        int                  pixels_checked;
        int                  line_starts;
        int                  line_steps;
        int                  useful_items;
        int                  screen_w;
        int                  screen_h;
        int                  cur_x;
        int                  cur_y;
        int                  far_x;
        int                  far_y;
        int                  steps_left;
        bit                  go_left;
        bit                  endpoint_due;
        bit                  drawing;
        line_kind_t          kind;
        bit [ERR_BITS-1:0]   err_acc;
        bit [ERR_BITS-1:0]   err_inc;

        function new();
            screen_w = 640;
            screen_h = 480;
            kind     = KIND_H;
        endfunction

        function void set_screen(int w, int h);
            screen_w = w;
            screen_h = h;
        endfunction

        function int pending();
            return pixel_queue.size();
        endfunction

        // visibility is judged on the unwrapped coordinates
        function void add_pixel(int x, int y, bit [COV_BITS-1:0] cov, bit lst, bit done);
            out_item_t p;
            p.pixel_x   = COORD_WIDTH'(x);
            p.pixel_y   = COORD_WIDTH'(y);
            p.coverage  = cov;
            p.visible   = x >= 0 && y >= 0 && x < screen_w && y < screen_h;
            p.last      = lst;
            p.line_done = done;
            pixel_queue.push_back(p);
        endfunction

        function void note_input(in_item_t it);
            int                 sx;
            int                 sy;
            int                 ex;
            int                 ey;
            int                 dx;
            int                 dy;
            int                 t;
            int                 major;
            int                 minor;
            int                 xdir;
            int                 nx;
            int                 ny;
            bit [ERR_BITS-1:0]  prev;
            bit [COV_BITS-1:0]  w;
            bit                 fin;
            bit                 ep;

            if (it.command == CMD_START) begin
                sx = it.start_x;
                sy = it.start_y;
                ex = it.end_x;
                ey = it.end_y;
                if (sy > ey) begin
                    t = sx; sx = ex; ex = t;
                    t = sy; sy = ey; ey = t;
                end
                cur_x = sx;
                cur_y = sy;
                far_x = ex;
                far_y = ey;
                dx = ex - sx;
                go_left = dx < 0;
                if (dx < 0)
                    dx = -dx;
                dy = ey - sy;
                err_acc      = '0;
                err_inc      = '0;
                endpoint_due = 1'b0;
                if (dy == 0) begin
                    kind       = KIND_H;
                    steps_left = dx;
                end else if (dx == 0) begin
                    kind       = KIND_V;
                    steps_left = dy;
                end else if (dx == dy) begin
                    kind       = KIND_D;
                    steps_left = dy;
                end else begin
                    major        = dy > dx ? dy : dx;
                    minor        = dy > dx ? dx : dy;
                    kind         = dy > dx ? KIND_YMAJ : KIND_XMAJ;
                    steps_left   = major - 1;
                    err_inc      = ERR_BITS'((longint'(minor) << ERR_BITS) / major);
                    endpoint_due = it.with_endpoint;
                end
                drawing = steps_left != 0;
                line_starts++;
                useful_items++;
                add_pixel(sx, sy, COV_FULL, 1'b1, !drawing);
                return;
            end

            // a step with no line in progress is dropped
            if (!drawing)
                return;

            line_steps++;
            useful_items++;
            xdir = go_left ? -1 : 1;
            steps_left--;

            if (kind == KIND_H || kind == KIND_V || kind == KIND_D) begin
                if (kind != KIND_V)
                    cur_x += xdir;
                if (kind != KIND_H)
                    cur_y += 1;
                drawing = steps_left != 0;
                add_pixel(cur_x, cur_y, COV_FULL, 1'b1, !drawing);
            end else begin
                prev    = err_acc;
                err_acc = err_acc + err_inc;
                // accumulator wrap moves the minor axis
                if (kind == KIND_YMAJ) begin
                    if (err_acc <= prev)
                        cur_x += xdir;
                    cur_y += 1;
                    nx = cur_x + xdir;
                    ny = cur_y;
                end else begin
                    if (err_acc <= prev)
                        cur_y += 1;
                    cur_x += xdir;
                    nx = cur_x;
                    ny = cur_y + 1;
                end
                w   = err_acc[ERR_BITS-1 -: COV_BITS];
                fin = steps_left == 0;
                ep  = fin && endpoint_due;
                add_pixel(cur_x, cur_y, COV_FULL - w, 1'b0, 1'b0);
                add_pixel(nx, ny, w, !ep, fin && !ep);
                if (fin)
                    drawing = 1'b0;
                if (ep)
                    add_pixel(far_x, far_y, COV_FULL, 1'b1, 1'b1);
            end
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: pixel %0d %s expected %0d, got %0d",
                             $time, pixels_checked, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pixel_queue.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected pixel x=%0d y=%0d cov=%0d, expected none",
                             $time, got.pixel_x, got.pixel_y, got.coverage);
                return;
            end
            want = pixel_queue.pop_front();
            compare_field("pixel_x", want.pixel_x, got.pixel_x);
            compare_field("pixel_y", want.pixel_y, got.pixel_y);
            compare_field("coverage", want.coverage, got.coverage);
            compare_field("visible", want.visible, got.visible);
            compare_field("last", want.last, got.last);
            compare_field("line_done", want.line_done, got.line_done);
            pixels_checked++;
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_VIEW_COLS;
    logic [SCREEN_BITS-1:0]   cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    in_item_t                 in_item   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    out_item_t                out_item;

    pixel_scoreboard sb = new();

    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int stuck_cycles = 0;
    int span_x = 48;
    int span_y = 48;
    int settings_used = 1;

    antialiased_line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // transfer monitor: inputs are noted before outputs of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("antialiased_line_rasterizer: mismatch");
        $finish;
    end

    // pixel receiver: random stall, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 37);
        end
    end

    function automatic in_item_t make_item(logic cmd, int sx, int sy, int ex, int ey,
                                           bit wep);
        in_item_t it;
        it.command       = cmd;
        it.start_x       = COORD_WIDTH'(sx);
        it.start_y       = COORD_WIDTH'(sy);
        it.end_x         = COORD_WIDTH'(ex);
        it.end_y         = COORD_WIDTH'(ey);
        it.with_endpoint = wep;
        return it;
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int edge_coord();
        return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 6))
                                    : -32768 + int'($urandom_range(0, 6));
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send(input in_item_t item);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < 37)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // step commands carry random, ignored endpoint fields
    task automatic send_steps(input int n);
        repeat (n)
            send(make_item(CMD_STEP, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(0, 1)));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_screen(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VIEW_COLS;
        cfg_data  <= SCREEN_BITS'(w);
        @(posedge clk);
        cfg_index <= REG_VIEW_ROWS;
        cfg_data  <= SCREEN_BITS'(h);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_screen(w, h);
        span_x = w < 48 ? w : 48;
        span_y = h < 48 ? h : 48;
    endtask

    task automatic random_line();
        int sx;
        int sy;
        int ex;
        int ey;
        int d;
        int adx;
        int ady;
        int nsteps;
        int pick;
        bit wep;
        pick = $urandom_range(0, 19);
        wep  = $urandom_range(0, 1);
        if (pick == 0)
        begin
            // full-range endpoints: a long line that is soon abandoned
            sx = $urandom_range(0, 65535) - 32768;
            sy = $urandom_range(0, 65535) - 32768;
            ex = $urandom_range(0, 65535) - 32768;
            ey = $urandom_range(0, 65535) - 32768;
            nsteps = $urandom_range(0, 5);
        end
        else
        begin
            if (pick == 1)
            begin
                sx = edge_coord();
                sy = edge_coord();
            end
            else
            begin
                sx = $urandom_range(0, span_x + 16) - 8;
                sy = $urandom_range(0, span_y + 16) - 8;
            end
            d = $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0:
                begin
                    ex = sx + ($urandom_range(0, 1) ? d : -d);
                    ey = sy;
                end
                1:
                begin
                    ex = sx;
                    ey = sy + ($urandom_range(0, 1) ? d : -d);
                end
                2:
                begin
                    ex = sx + ($urandom_range(0, 1) ? d : -d);
                    ey = sy + ($urandom_range(0, 1) ? d : -d);
                end
                default:
                begin
                    ex = sx + int'($urandom_range(0, 2 * d)) - d;
                    ey = sy + int'($urandom_range(0, 2 * d)) - d;
                end
            endcase
            ex = clamp_coord(ex);
            ey = clamp_coord(ey);
            adx = ex > sx ? ex - sx : sx - ex;
            ady = ey > sy ? ey - sy : sy - ey;
            nsteps = (adx > ady ? adx : ady) + int'($urandom_range(0, 1));
            // some lines are cut short by the next start
            if ($urandom_range(0, 4) == 0)
                nsteps = $urandom_range(0, nsteps);
        end
        send(make_item(CMD_START, sx, sy, ex, ey, wep));
        send_steps(nsteps);
    endtask

    // the long hold-off starts once commands are being offered again
    task automatic run_phase(input int w, input int h, input int n_items,
                             input bit with_hold);
        int target;
        settle();
        program_screen(w, h);
        settings_used++;
        if (with_hold)
            hold_req = 1'b1;
        target = sb.useful_items + n_items;
        while (sb.useful_items < target)
            random_line();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines under the reset screen size
        send_steps(1);                                           // step while idle
        send(make_item(CMD_START, 5, 5, 5, 5, 1'b1));            // zero length
        send(make_item(CMD_START, 10, 3, 7, 3, 1'b0));           // horizontal, leftward
        send_steps(3);
        send(make_item(CMD_START, 2, 8, 2, 6, 1'b0));            // vertical, swapped
        send_steps(2);
        send(make_item(CMD_START, 3, 0, 1, 2, 1'b1));            // diagonal, leftward
        send_steps(2);
        send(make_item(CMD_START, 0, 0, 1, 3, 1'b1));            // y-major with endpoint
        send_steps(2);
        send(make_item(CMD_START, 4, 1, 1, 2, 1'b0));            // x-major, leftward
        send_steps(2);
        send(make_item(CMD_START, 0, 0, 100, 7, 1'b1));          // abandoned by next start
        send_steps(1);
        send(make_item(CMD_START, 32765, 0, 32767, 3, 1'b1));    // neighbor at column limit
        send_steps(2);
        send(make_item(CMD_START, 0, 32765, 4, 32767, 1'b0));    // neighbor at row limit
        send_steps(3);
        send(make_item(CMD_START, -32768, -32768, 32767, 32767, 1'b0));
        send_steps(1);
        send(make_item(CMD_START, 32767, -32768, -32768, 32767, 1'b1));
        send_steps(1);

        run_phase(1, 1, 35, 1'b0);
        quiet = 1'b1;
        run_phase(32767, 32767, 35, 1'b0);
        quiet = 1'b0;
        run_phase(0, 0, 25, 1'b0);
        run_phase(16, 12, 40, 1'b1);
        run_phase($urandom_range(1, 32767), $urandom_range(1, 32767), 35, 1'b0);
        run_phase(200, 150, 35, 1'b0);
        settle();

        $display("covered %0d line starts and %0d steps, %0d pixels checked",
                 sb.line_starts, sb.line_steps, sb.pixels_checked);
        $display("across %0d screen settings, %0d field mismatches",
                 settings_used, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("antialiased_line_rasterizer: match");
        else
            $display("antialiased_line_rasterizer: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hdl/alr_pkg.sv
hdl/alr_div.sv
hdl/alr_front.sv
hdl/alr_fifo.sv
hdl/alr_back.sv
hdl/antialiased_line_rasterizer.sv
tb/tb_top.sv
